/* design/lsrc_pkg.sv */
package lsrc_pkg;

  localparam int COORD_BITS = 16;
  // signed width that holds a boundary p or q and every t numerator or denominator
  localparam int NUM_BITS   = COORD_BITS + 2;
  localparam int PROD_BITS  = 2 * NUM_BITS;
  // unsigned divisor width, the denominator never exceeds 2**COORD_BITS - 1
  localparam int DIV_BITS   = COORD_BITS + 1;
  localparam int N_BOUND    = 4;
  localparam int N_LANES    = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [NUM_BITS-1:0]   num_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic                         visible;
    logic signed [COORD_BITS-1:0] clip_start_x;
    logic signed [COORD_BITS-1:0] clip_start_y;
    logic signed [COORD_BITS-1:0] clip_end_x;
    logic signed [COORD_BITS-1:0] clip_end_y;
  } clip_t;

  // state handed from one boundary cell to the next
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [NUM_BITS-1:0]   dx;
    logic signed [NUM_BITS-1:0]   dy;
    logic [N_BOUND-1:0][NUM_BITS-1:0] p;
    logic [N_BOUND-1:0][NUM_BITS-1:0] q;
    logic signed [NUM_BITS-1:0]   n1;
    logic signed [NUM_BITS-1:0]   d1;
    logic signed [NUM_BITS-1:0]   n2;
    logic signed [NUM_BITS-1:0]   d2;
    logic                         reject;
  } bnd_t;

  typedef struct packed {
    logic                  neg;
    logic [DIV_BITS-1:0]   rem;
    // dividend bits still to shift in on top, quotient bits growing below
    logic [COORD_BITS-1:0] lq;
  } lane_t;

  // state handed from one divider cell to the next
  typedef struct packed {
    logic                       vis;
    lane_t [N_LANES-1:0]        lane;
    logic [DIV_BITS-1:0]        d1;
    logic [DIV_BITS-1:0]        d2;
  } div_t;

endpackage

/* design/lsrc_bound_cell.sv */
module lsrc_bound_cell #(
  parameter int IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lsrc_pkg::bnd_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lsrc_pkg::bnd_t  out_data_o
);

  logic           valid_q;
  lsrc_pkg::bnd_t data_q, data_d;

  always_comb begin
    lsrc_pkg::num_t p, q, num, den, nc, dc;
    logic signed [lsrc_pkg::PROD_BITS-1:0] a, b;
    p = $signed(in_data_i.p[IDX]);
    q = $signed(in_data_i.q[IDX]);
    num = (p < 0) ? -q : q;
    den = (p < 0) ? -p : p;
    nc = (p < 0) ? in_data_i.n1 : in_data_i.n2;
    dc = (p < 0) ? in_data_i.d1 : in_data_i.d2;
    a = num * dc;
    b = nc * den;
    data_d = in_data_i;
    if (p == 0) begin
      if (q < 0) data_d.reject = 1'b1;
    end else if (p < 0) begin
      // entry side, raise t1
      if (a > b) begin
        data_d.n1 = num;
        data_d.d1 = den;
      end
    end else begin
      // exit side, lower t2
      if (a < b) begin
        data_d.n2 = num;
        data_d.d2 = den;
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/lsrc_div_cell.sv */
module lsrc_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lsrc_pkg::div_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lsrc_pkg::div_t  out_data_o
);

  logic           valid_q;
  lsrc_pkg::div_t data_q, data_d;

  // one restoring step on every lane
  always_comb begin
    logic [lsrc_pkg::DIV_BITS:0]   t, dd, r;
    logic                          ge;
    data_d = in_data_i;
    for (int k = 0; k < lsrc_pkg::N_LANES; k++) begin
      dd = (k < 2) ? {1'b0, in_data_i.d1} : {1'b0, in_data_i.d2};
      t  = {in_data_i.lane[k].rem, in_data_i.lane[k].lq[lsrc_pkg::COORD_BITS-1]};
      ge = (t >= dd);
      r  = ge ? (t - dd) : t;
      data_d.lane[k].rem = r[lsrc_pkg::DIV_BITS-1:0];
      data_d.lane[k].lq  = {in_data_i.lane[k].lq[lsrc_pkg::COORD_BITS-2:0], ge};
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/line_segment_rect_clipper_top.sv */
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i  (lsrc_pkg::seg_t)
// out       output     out_valid_o / out_ready_i out_data_o (lsrc_pkg::clip_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one segment per cycle unless the output stalls; the pipeline holds, in order:
// one setup stage, four boundary cells, one product stage, one divider cell per
// coordinate bit for the four endpoint divisions, one output register.
// every stage holds its own beat, so a stall on the output only backs up stages that are full.
// reset clears the valid bits and the window registers.
module line_segment_rect_clipper_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  lsrc_pkg::seg_t                        in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output lsrc_pkg::clip_t                       out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [lsrc_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [lsrc_pkg::COORD_BITS-1:0]       cfg_wdata_i
);

  localparam int CW = lsrc_pkg::COORD_BITS;
  localparam int NW = lsrc_pkg::NUM_BITS;
  localparam int PW = lsrc_pkg::PROD_BITS;
  localparam int DU = lsrc_pkg::DIV_BITS;

  lsrc_pkg::coord_t x_min_q, y_min_q, x_max_q, y_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= '0;
      y_min_q <= '0;
      x_max_q <= '0;
      y_max_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsrc_pkg::REG_X_MIN: x_min_q <= cfg_wdata_i;
        lsrc_pkg::REG_Y_MIN: y_min_q <= cfg_wdata_i;
        lsrc_pkg::REG_X_MAX: x_max_q <= cfg_wdata_i;
        lsrc_pkg::REG_Y_MAX: y_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // setup stage: p and q of the four boundaries
  logic           v0_q;
  lsrc_pkg::bnd_t b0_d, b0_q;
  logic [lsrc_pkg::N_BOUND:0] bv, br;
  lsrc_pkg::bnd_t             bd [lsrc_pkg::N_BOUND+1];

  always_comb begin
    lsrc_pkg::num_t x1, y1, dx, dy;
    x1 = NW'(in_data_i.start_x);
    y1 = NW'(in_data_i.start_y);
    dx = NW'(in_data_i.end_x) - x1;
    dy = NW'(in_data_i.end_y) - y1;
    b0_d.x1 = in_data_i.start_x;
    b0_d.y1 = in_data_i.start_y;
    b0_d.dx = dx;
    b0_d.dy = dy;
    b0_d.p[0] = -dx;
    b0_d.p[1] = dx;
    b0_d.p[2] = -dy;
    b0_d.p[3] = dy;
    b0_d.q[0] = x1 - NW'(x_min_q);
    b0_d.q[1] = NW'(x_max_q) - x1;
    b0_d.q[2] = y1 - NW'(y_min_q);
    b0_d.q[3] = NW'(y_max_q) - y1;
    b0_d.n1 = NW'(0);
    b0_d.d1 = NW'(1);
    b0_d.n2 = NW'(1);
    b0_d.d2 = NW'(1);
    b0_d.reject = 1'b0;
  end

  assign in_ready_o = !v0_q || br[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (in_ready_o) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      b0_q <= b0_d;
    end
  end

  assign bv[0] = v0_q;
  assign bd[0] = b0_q;

  for (genvar g = 0; g < lsrc_pkg::N_BOUND; g++) begin : g_bound
    lsrc_bound_cell #(.IDX(g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (bv[g]),
      .in_ready_o (br[g]),
      .in_data_i  (bd[g]),
      .out_valid_o(bv[g+1]),
      .out_ready_i(br[g+1]),
      .out_data_o (bd[g+1])
    );
  end

  // product stage: final t compare and the four endpoint numerators
  logic           vf_q;
  lsrc_pkg::div_t f_d, f_q;
  logic [CW:0]    dv, dr;
  lsrc_pkg::div_t dd [CW+1];

  always_comb begin
    lsrc_pkg::bnd_t b;
    logic signed [PW-1:0] c1, c2;
    logic signed [PW:0]   nv [lsrc_pkg::N_LANES];
    logic [PW:0]          mag;
    b  = bd[lsrc_pkg::N_BOUND];
    c1 = b.n1 * b.d2;
    c2 = b.n2 * b.d1;
    nv[0] = (PW+1)'(b.x1) * b.d1 + (PW+1)'(b.n1) * b.dx;
    nv[1] = (PW+1)'(b.y1) * b.d1 + (PW+1)'(b.n1) * b.dy;
    nv[2] = (PW+1)'(b.x1) * b.d2 + (PW+1)'(b.n2) * b.dx;
    nv[3] = (PW+1)'(b.y1) * b.d2 + (PW+1)'(b.n2) * b.dy;
    f_d.vis = !b.reject && (c1 <= c2);
    f_d.d1  = b.d1[DU-1:0];
    f_d.d2  = b.d2[DU-1:0];
    for (int k = 0; k < lsrc_pkg::N_LANES; k++) begin
      mag = (nv[k] < 0) ? -nv[k] : nv[k];
      f_d.lane[k].neg = nv[k] < 0;
      // quotient fits the coordinate width, so the upper part is already below the divisor
      f_d.lane[k].rem = mag[CW +: DU];
      f_d.lane[k].lq  = mag[CW-1:0];
    end
  end

  assign br[lsrc_pkg::N_BOUND] = !vf_q || dr[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (br[lsrc_pkg::N_BOUND]) begin
      vf_q <= bv[lsrc_pkg::N_BOUND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bv[lsrc_pkg::N_BOUND] && br[lsrc_pkg::N_BOUND]) begin
      f_q <= f_d;
    end
  end

  assign dv[0] = vf_q;
  assign dd[0] = f_q;

  for (genvar g = 0; g < CW; g++) begin : g_div
    lsrc_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (dv[g]),
      .in_ready_o (dr[g]),
      .in_data_i  (dd[g]),
      .out_valid_o(dv[g+1]),
      .out_ready_i(dr[g+1]),
      .out_data_o (dd[g+1])
    );
  end

  // output register: sign back on, rejected segments read as zero
  logic            vo_q;
  lsrc_pkg::clip_t o_d, o_q;
  lsrc_pkg::coord_t cv [lsrc_pkg::N_LANES];

  always_comb begin
    lsrc_pkg::div_t r;
    r = dd[CW];
    for (int k = 0; k < lsrc_pkg::N_LANES; k++) begin
      cv[k] = !r.vis ? '0 :
              r.lane[k].neg ? -$signed(r.lane[k].lq) : $signed(r.lane[k].lq);
    end
    o_d.visible      = r.vis;
    o_d.clip_start_x = cv[0];
    o_d.clip_start_y = cv[1];
    o_d.clip_end_x   = cv[2];
    o_d.clip_end_y   = cv[3];
  end

  assign dr[CW] = !vo_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (dr[CW]) begin
      vo_q <= dv[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv[CW] && dr[CW]) begin
      o_q <= o_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = o_q;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.visible |->
      out_data_o.clip_start_x == 0 && out_data_o.clip_start_y == 0 &&
      out_data_o.clip_end_x == 0 && out_data_o.clip_end_y == 0)
    else $error("rejected segment with nonzero coordinates");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v0_q |-> in_ready_o)
    else $error("empty setup stage refuses a beat");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vf_q |-> f_q.d1 != 0 && f_q.d2 != 0)
    else $error("zero divisor entering divider chain");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vo_q |-> dr[CW])
    else $error("empty output register stalls divider chain");

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 23;
  localparam int N_RANDOM  = 400;
  localparam longint CYCLE_LIMIT = 400000;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  lsrc_pkg::seg_t   in_data_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  lsrc_pkg::clip_t  out_data_o;
  logic   cfg_we_i = 1'b0;
  logic [lsrc_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = lsrc_pkg::REG_X_MIN;
  logic [lsrc_pkg::COORD_BITS-1:0]   cfg_wdata_i = '0;

  line_segment_rect_clipper_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // window registers as the predictor sees them
  longint win_x_min, win_y_min, win_x_max, win_y_max;

  lsrc_pkg::seg_t  seg_pending[$];
  lsrc_pkg::clip_t clip_expected[$];
  int    send_idle_pct, recv_idle_pct;
  int    n_errors, n_checked, n_visible;
  longint cycle_count;
  logic accepted_last = 1'b0;

  function automatic longint trunc_point(longint base, longint delta, longint num, longint den);
    return (base * den + num * delta) / den;
  endfunction

  function automatic lsrc_pkg::clip_t clip_segment(lsrc_pkg::seg_t s);
    longint x1, y1, dx, dy, n1, d1, n2, d2, num, den;
    longint p[4], q[4];
    bit reject;
    lsrc_pkg::clip_t r;
    x1 = s.start_x; y1 = s.start_y;
    dx = longint'(s.end_x) - x1;
    dy = longint'(s.end_y) - y1;
    p[0] = -dx; q[0] = x1 - win_x_min;
    p[1] = dx;  q[1] = win_x_max - x1;
    p[2] = -dy; q[2] = y1 - win_y_min;
    p[3] = dy;  q[3] = win_y_max - y1;
    n1 = 0; d1 = 1; n2 = 1; d2 = 1; reject = 0;
    for (int i = 0; i < 4; i++) begin
      if (p[i] == 0) begin
        if (q[i] < 0) reject = 1;
      end else if (p[i] < 0) begin
        num = -q[i]; den = -p[i];
        if (num * d1 > n1 * den) begin
          n1 = num; d1 = den;
        end
      end else begin
        num = q[i]; den = p[i];
        if (num * d2 < n2 * den) begin
          n2 = num; d2 = den;
        end
      end
    end
    r = '0;
    if (!reject && n1 * d2 <= n2 * d1) begin
      r.visible      = 1'b1;
      r.clip_start_x = lsrc_pkg::coord_t'(trunc_point(x1, dx, n1, d1));
      r.clip_start_y = lsrc_pkg::coord_t'(trunc_point(y1, dy, n1, d1));
      r.clip_end_x   = lsrc_pkg::coord_t'(trunc_point(x1, dx, n2, d2));
      r.clip_end_y   = lsrc_pkg::coord_t'(trunc_point(y1, dy, n2, d2));
    end
    return r;
  endfunction

  // driver: keeps valid high until the beat is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || accepted_last) begin
        if (seg_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= seg_pending.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predicts on input beats and checks output beats
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    accepted_last <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o)
      clip_expected.push_back(clip_segment(in_data_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (clip_expected.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data_o);
        n_errors++;
      end else begin
        lsrc_pkg::clip_t e;
        e = clip_expected.pop_front();
        n_checked++;
        if (e.visible) n_visible++;
        if (e.visible !== out_data_o.visible ||
            e.clip_start_x !== out_data_o.clip_start_x ||
            e.clip_start_y !== out_data_o.clip_start_y ||
            e.clip_end_x !== out_data_o.clip_end_x ||
            e.clip_end_y !== out_data_o.clip_end_y) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, e, out_data_o);
          n_errors++;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_window(logic [lsrc_pkg::CFG_IDX_BITS-1:0] idx, lsrc_pkg::coord_t value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lsrc_pkg::REG_X_MIN: win_x_min = value;
      lsrc_pkg::REG_Y_MIN: win_y_min = value;
      lsrc_pkg::REG_X_MAX: win_x_max = value;
      default:             win_y_max = value;
    endcase
  endtask

  task automatic set_window(lsrc_pkg::coord_t xl, lsrc_pkg::coord_t yl,
                            lsrc_pkg::coord_t xh, lsrc_pkg::coord_t yh);
    write_window(lsrc_pkg::REG_X_MIN, xl);
    write_window(lsrc_pkg::REG_Y_MIN, yl);
    write_window(lsrc_pkg::REG_X_MAX, xh);
    write_window(lsrc_pkg::REG_Y_MAX, yh);
  endtask

  task automatic drain();
    while (seg_pending.size() > 0 || in_valid_i || clip_expected.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic add_seg(lsrc_pkg::coord_t x1, lsrc_pkg::coord_t y1,
                         lsrc_pkg::coord_t x2, lsrc_pkg::coord_t y2);
    lsrc_pkg::seg_t s;
    s.start_x = x1; s.start_y = y1; s.end_x = x2; s.end_y = y2;
    seg_pending.push_back(s);
  endtask

  // mostly coordinates near the window, sometimes anywhere
  function automatic lsrc_pkg::coord_t near(longint lo, longint hi);
    longint span;
    if ($urandom_range(3) == 0) return lsrc_pkg::coord_t'($urandom);
    span = (hi > lo) ? hi - lo : lo - hi;
    span = span + 64;
    return lsrc_pkg::coord_t'((lo < hi ? lo : hi) - span / 4 +
                              longint'($urandom_range(span * 3 / 2)));
  endfunction

  task automatic add_random(int n);
    repeat (n)
      add_seg(near(win_x_min, win_x_max), near(win_y_min, win_y_max),
              near(win_x_min, win_x_max), near(win_y_min, win_y_max));
  endtask

  initial begin
    win_x_min = 0; win_y_min = 0; win_x_max = 0; win_y_max = 0;
    n_errors = 0; n_checked = 0; n_visible = 0; cycle_count = 0;
    send_idle_pct = 14; recv_idle_pct = 56;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset window is a single point at the origin
    add_seg(0, 0, 0, 0);
    add_seg(-5, 0, 5, 0);
    add_seg(1, 1, 1, 1);
    drain();

    set_window(-100, -50, 100, 50);
    add_seg(0, 0, 10, 10);
    add_seg(-200, 0, 200, 0);
    add_seg(0, -200, 0, 200);
    add_seg(-200, -200, 200, 200);
    add_seg(200, 200, -200, -200);
    add_seg(100, 50, 200, 100);
    add_seg(-300, 60, 300, 60);
    add_seg(150, -10, 150, 10);
    add_seg(7, 7, 7, 7);
    add_seg(500, 7, 500, 7);
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, -32768, -32768, 32767);
    add_seg(-32768, 0, 32767, 1);
    add_seg(-101, 40, -80, 60);
    drain();

    set_window(-32768, -32768, 32767, 32767);
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, 32767, -32768, -32768);
    add_seg(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555);
    add_random(60);
    drain();

    // inverted window
    set_window(100, 100, -100, -100);
    add_seg(0, 0, 0, 0);
    add_seg(-200, -200, 200, 200);
    add_random(30);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 14 : 0;
      set_window(-lsrc_pkg::coord_t'($urandom_range(2000)),
                 -lsrc_pkg::coord_t'($urandom_range(2000)),
                 lsrc_pkg::coord_t'($urandom_range(2000)),
                 lsrc_pkg::coord_t'($urandom_range(2000)));
      add_random(N_RANDOM / 8);
      drain();
      set_window(lsrc_pkg::coord_t'($urandom), lsrc_pkg::coord_t'($urandom),
                 lsrc_pkg::coord_t'($urandom), lsrc_pkg::coord_t'($urandom));
      add_random(N_RANDOM / 8);
      drain();
    end

    $display("checked %0d clipped segments, %0d visible, over several windows",
             n_checked, n_visible);
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
